[hdl/six_step_motor_ramp_commutator_macros.svh]
// assertion macros for the six-step commutator
// used by the top level; no other dependencies
`ifndef SIX_STEP_MOTOR_RAMP_COMMUTATOR_MACROS_SVH
`define SIX_STEP_MOTOR_RAMP_COMMUTATOR_MACROS_SVH

// property checked on the rising clock edge, off during reset
`define SSMRC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication checked on the rising clock edge, off during reset
`define SSMRC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/ssmrc_pkg.sv]
// shared types and constants for the six-step commutator
// no dependencies
package ssmrc_pkg;

    // item opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_COMM  = 2'd1;
    localparam logic [1:0] OP_TWR   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WORK_FREQ   = 2'd0;
    localparam logic [1:0] CFG_MIN_FREQ    = 2'd1;
    localparam logic [1:0] CFG_START_STEPS = 2'd2;
    localparam logic [1:0] CFG_STOP_STEPS  = 2'd3;

    // divider sizing
    localparam int DIV_BITS = 24;
    localparam logic [DIV_BITS-1:0] FREQ_DIVIDEND = 24'd5208;

    // gate drive bits
    localparam logic [5:0] G_AH = 6'h01;
    localparam logic [5:0] G_AL = 6'h02;
    localparam logic [5:0] G_BH = 6'h04;
    localparam logic [5:0] G_BL = 6'h08;
    localparam logic [5:0] G_CH = 6'h10;
    localparam logic [5:0] G_CL = 6'h20;

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_FIN  = 8'b0000_1000,
        S_PLD  = 8'b0001_0000,
        S_PDIV = 8'b0010_0000,
        S_RD   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    // next gate pattern for one commutation step
    function automatic logic [5:0] comm_gates(input logic [5:0] g, input logic [2:0] ph,
                                              input logic back);
        logic [5:0] r;
        r = g;
        if (!back) begin
            unique case (ph)
                3'd1: r = (g & ~G_CH) | G_BH;
                3'd2: r = (g & ~G_AL) | G_CL;
                3'd3: r = (g & ~G_BH) | G_AH;
                3'd4: r = (g & ~G_CL) | G_BL;
                3'd5: r = (g & ~G_AH) | G_CH;
                3'd6: r = (g & ~G_BL) | G_AL;
                default: r = g;
            endcase
        end else begin
            unique case (ph)
                3'd6: r = (g | G_CH) & ~G_BH;
                3'd5: r = (g | G_AL) & ~G_CL;
                3'd4: r = (g | G_BH) & ~G_AH;
                3'd3: r = (g | G_CL) & ~G_BL;
                3'd2: r = (g | G_AH) & ~G_CH;
                3'd1: r = (g | G_BL) & ~G_AL;
                default: r = g;
            endcase
        end
        return r;
    endfunction

endpackage

[hdl/ssmrc_ram.sv]
// generic memory, one write port and one registered read port
// no dependencies
module ssmrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 50
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

[hdl/six_step_motor_ramp_commutator.sv]
// six-step commutator with linear soft start and soft stop, top level
// depends on ssmrc_pkg, ssmrc_ram and the macros header
//
//  channel | direction | handshake        | content
//  s_      | in        | tvalid / tready  | tuser opcode, tdata requests and table write
//  m_      | out       | tvalid / tready  | tdata gates, period, duty, frequency, status
//  cfg_    | in        | cfg_wr_en        | register index and data, no wait
//
// a ramp step is a multiply, a 24-step serial divide and an update, and a tick runs
// at most two; then come the period divide load and serial divide, the table read and the output load.
// reset is synchronous; valid bits stand in for clearing the power table.
// s_tready is high only while idle; a stalled result holds in the output register.
`include "six_step_motor_ramp_commutator_macros.svh"
module six_step_motor_ramp_commutator #(
    parameter int TABLE_ENTRIES = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] start_req, [1] stop_req, [2] reverse_req, [8:3] table_index, [16:9] table_value
    input  logic [23:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] gate_bits, [18:6] period_div, [26:19] pwm_duty, [34:27] current_freq,
    // [35] stopped, [36] reversed
    output logic [39:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import ssmrc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [8:0] LAST_IDX = 9'(TABLE_ENTRIES - 1);
    localparam logic [4:0] DIV_LAST = 5'(DIV_BITS - 1);

    // configuration
    logic [7:0]  work_freq_reg, min_freq_reg;
    logic [14:0] start_steps_reg, stop_steps_reg;

    // motor state
    logic        starting_reg, stopping_reg, running_reg, reversing_reg, dir_back_reg;
    logic [14:0] ramp_count_reg;
    logic [7:0]  cur_freq_reg;
    logic [2:0]  phase_reg;
    logic [5:0]  gate_reg;
    logic [TABLE_ENTRIES-1:0] tbl_valid_reg;

    // sequencer and shared divider
    state_t              state_reg;
    logic                ramp_stop_reg;
    logic [15:0]         next_cnt_reg;
    logic                neg_reg;
    logic [DIV_BITS-1:0] dvd_reg;
    logic [15:0]         rem_reg;
    logic [14:0]         dvs_reg;
    logic [4:0]          cnt_reg;
    logic [12:0]         period_reg;
    logic                dvalid_reg;

    // output register
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    // input fields
    logic       in_start, in_stop, in_rev;
    logic [5:0] in_tidx;
    logic [7:0] in_tval;
    assign in_start = s_tdata[0];
    assign in_stop  = s_tdata[1];
    assign in_rev   = s_tdata[2];
    assign in_tidx  = s_tdata[8:3];
    assign in_tval  = s_tdata[16:9];

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // request latching for a tick
    logic st_l, sp_l, rv_l, dir_l;
    always_comb begin
        st_l  = starting_reg | in_start;
        sp_l  = stopping_reg | in_stop;
        rv_l  = reversing_reg | in_rev;
        dir_l = dir_back_reg;
        if (st_l && sp_l) begin
            st_l = 1'b0;
        end
        if (rv_l && !running_reg) begin
            dir_l = ~dir_l;
            rv_l  = 1'b0;
        end
        if (rv_l && running_reg) begin
            sp_l = 1'b1;
        end
    end

    // table write address
    logic [8:0]       wr_ext;
    logic             tbl_we;
    logic [IDX_W-1:0] wr_addr;
    assign wr_ext  = {3'b000, in_tidx};
    assign wr_addr = wr_ext[IDX_W-1:0];
    assign tbl_we  = accept && (s_tuser == OP_TWR) && (wr_ext < 9'(TABLE_ENTRIES));

    // table read address, frequency clamped to the last entry
    logic [8:0]       rd_ext;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    assign rd_ext  = ({1'b0, cur_freq_reg} > LAST_IDX) ? LAST_IDX : {1'b0, cur_freq_reg};
    assign rd_addr = rd_ext[IDX_W-1:0];

    ssmrc_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (wr_addr),
        .wr_data (in_tval),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ramp multiply operands
    logic signed [8:0] d_ramp;
    logic [7:0]        d_abs;
    logic [15:0]       next_cnt;
    logic [14:0]       steps_sel;
    assign d_ramp    = $signed({1'b0, work_freq_reg}) - $signed({1'b0, min_freq_reg});
    assign d_abs     = d_ramp[8] ? 8'(-d_ramp) : d_ramp[7:0];
    assign next_cnt  = {1'b0, ramp_count_reg} + 16'd1;
    assign steps_sel = ramp_stop_reg ? stop_steps_reg : start_steps_reg;

    // one restoring divide step
    logic [15:0] rem_sh;
    logic        q_bit;
    logic [15:0] rem_nx;
    assign rem_sh = {rem_reg[14:0], dvd_reg[DIV_BITS-1]};
    assign q_bit  = (rem_sh >= {1'b0, dvs_reg});
    assign rem_nx = q_bit ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;

    // ramp frequency from the quotient, saturated
    logic signed [25:0] q_s, f_s;
    logic [7:0]         f_set;
    logic [15:0]        lim;
    always_comb begin
        q_s = neg_reg ? -$signed({2'b00, dvd_reg}) : $signed({2'b00, dvd_reg});
        if (ramp_stop_reg) begin
            f_s = $signed({18'd0, work_freq_reg}) - q_s;
        end else begin
            f_s = q_s + $signed({18'd0, min_freq_reg});
        end
        priority if (f_s <= 26'sd0) begin
            f_set = min_freq_reg;
        end else if (f_s > 26'sd255) begin
            f_set = 8'd255;
        end else begin
            f_set = f_s[7:0];
        end
        lim = {1'b0, ((steps_sel == 15'd0) ? 15'd1 : steps_sel)};
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_freq_reg   <= 8'd40;
            min_freq_reg    <= 8'd1;
            start_steps_reg <= 15'd200;
            stop_steps_reg  <= 15'd200;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WORK_FREQ:   work_freq_reg   <= cfg_data[7:0];
                CFG_MIN_FREQ:    min_freq_reg    <= cfg_data[7:0];
                CFG_START_STEPS: start_steps_reg <= cfg_data;
                CFG_STOP_STEPS:  stop_steps_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, state and shared divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            starting_reg   <= 1'b0;
            stopping_reg   <= 1'b0;
            running_reg    <= 1'b0;
            reversing_reg  <= 1'b0;
            dir_back_reg   <= 1'b0;
            ramp_count_reg <= 15'd1;
            cur_freq_reg   <= 8'd40;
            phase_reg      <= 3'd1;
            gate_reg       <= 6'd0;
            tbl_valid_reg  <= '0;
            ramp_stop_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // the output step reloads the register itself when it is taken
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            if (tbl_we) begin
                tbl_valid_reg[wr_addr] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        unique case (s_tuser)
                            OP_TICK: begin
                                starting_reg  <= st_l;
                                stopping_reg  <= sp_l;
                                reversing_reg <= rv_l;
                                dir_back_reg  <= dir_l;
                                ramp_stop_reg <= !st_l;
                                state_reg     <= (st_l || sp_l) ? S_MUL : S_PLD;
                            end
                            OP_COMM: begin
                                if (!(running_reg || starting_reg)) begin
                                    gate_reg  <= 6'd0;
                                    phase_reg <= 3'd1;
                                end else begin
                                    gate_reg  <= comm_gates(gate_reg, phase_reg, dir_back_reg);
                                    phase_reg <= (phase_reg >= 3'd6) ? 3'd1 : phase_reg + 3'd1;
                                end
                                state_reg <= S_PLD;
                            end
                            default: state_reg <= S_PLD;
                        endcase
                    end
                end
                S_MUL: begin
                    next_cnt_reg <= next_cnt;
                    neg_reg      <= d_ramp[8];
                    dvd_reg      <= {8'd0, next_cnt} * {16'd0, d_abs};
                    dvs_reg      <= (steps_sel == 15'd0) ? 15'd1 : steps_sel;
                    rem_reg      <= 16'd0;
                    cnt_reg      <= 5'd0;
                    state_reg    <= S_DIV;
                end
                S_DIV, S_PDIV: begin
                    rem_reg <= rem_nx;
                    dvd_reg <= {dvd_reg[DIV_BITS-2:0], q_bit};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= (state_reg == S_DIV) ? S_FIN : S_RD;
                    end
                end
                S_FIN: begin
                    cur_freq_reg <= f_set;
                    if (next_cnt_reg > lim) begin
                        ramp_count_reg <= 15'd1;
                        if (ramp_stop_reg) begin
                            running_reg  <= 1'b0;
                            stopping_reg <= 1'b0;
                            if (reversing_reg) begin
                                starting_reg <= 1'b1;
                            end
                        end else begin
                            running_reg  <= 1'b1;
                            starting_reg <= 1'b0;
                        end
                    end else begin
                        ramp_count_reg <= next_cnt_reg[14:0];
                    end
                    if (!ramp_stop_reg && stopping_reg) begin
                        ramp_stop_reg <= 1'b1;
                        state_reg     <= S_MUL;
                    end else begin
                        state_reg <= S_PLD;
                    end
                end
                S_PLD: begin
                    dvd_reg   <= FREQ_DIVIDEND;
                    dvs_reg   <= (cur_freq_reg == 8'd0) ? 15'd1 : {7'd0, cur_freq_reg};
                    rem_reg   <= 16'd0;
                    cnt_reg   <= 5'd0;
                    state_reg <= S_PDIV;
                end
                S_RD: begin
                    period_reg <= dvd_reg[12:0];
                    dvalid_reg <= tbl_valid_reg[rd_addr];
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'd0, dir_back_reg,
                                         !(running_reg || starting_reg || stopping_reg),
                                         cur_freq_reg,
                                         ((running_reg || starting_reg) && dvalid_reg)
                                             ? rd_data : 8'd0,
                                         period_reg, gate_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SSMRC_ASSERT(a_state_onehot, aclk, aresetn, $onehot(state_reg), "state not one-hot")
    `SSMRC_ASSERT_IMP(a_div_bound, aclk, aresetn, (state_reg == S_DIV) || (state_reg == S_PDIV), cnt_reg <= DIV_LAST, "divider ran past its last step")
    `SSMRC_ASSERT_IMP(a_period_nonzero, aclk, aresetn, m_tvalid_reg, m_tdata_reg[18:6] != 13'd0, "period divisor is zero")
    `SSMRC_ASSERT_IMP(a_out_only_from_seq, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == S_OUT, "result raised outside the output step")
endmodule
